// File: hdl/ttb_pkg.sv
// Shared types and constants for the triangle tangent and bitangent block.
// Used by every module in this folder; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package ttb_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    // Edge delta width, exact product width, accumulator width.
    localparam int DW1 = DATA_WIDTH + 1;
    localparam int PW  = 2 * DW1;
    localparam int NW  = PW + 1;
    // Dividend width after the fraction shift.
    localparam int NSW = NW + FRAC_BITS;
    localparam int CW  = $clog2(NSW);
    // Component select: 0..2 tangent, 3..5 bitangent, then the determinant.
    localparam logic [2:0] SEL_LAST = 3'd5;
    localparam logic [2:0] SEL_DET  = 3'd6;
    localparam logic [2:0] SEL_BIT0 = 3'd3;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] pos_x;
        logic signed [DATA_WIDTH-1:0] pos_y;
        logic signed [DATA_WIDTH-1:0] pos_z;
        logic signed [DATA_WIDTH-1:0] tex_u;
        logic signed [DATA_WIDTH-1:0] tex_v;
    } vertex_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] tangent_x;
        logic signed [DATA_WIDTH-1:0] tangent_y;
        logic signed [DATA_WIDTH-1:0] tangent_z;
        logic signed [DATA_WIDTH-1:0] bitangent_x;
        logic signed [DATA_WIDTH-1:0] bitangent_y;
        logic signed [DATA_WIDTH-1:0] bitangent_z;
        logic                         degenerate;
        logic                         saturated;
    } result_t;

    // Edge deltas of one triangle, index 0..2 is x, y, z.
    typedef struct packed {
        logic [2:0][DW1-1:0] dp1;
        logic [2:0][DW1-1:0] dp2;
        logic [DW1-1:0]      du1;
        logic [DW1-1:0]      dv1;
        logic [DW1-1:0]      du2;
        logic [DW1-1:0]      dv2;
    } job_t;

    typedef struct packed {
        logic push;
        logic full;
    } queue_ctl_t;

    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_SECOND = 2'd1,
        PH_THIRD  = 2'd2
    } phase_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_SUB,
        S_ABS,
        S_DIV,
        S_ROUND,
        S_SAT,
        S_DONE
    } back_state_t;

endpackage

`default_nettype wire

// File: hdl/triangle_tangent_bitangent.sv
// Top level of the triangle tangent and bitangent block.
// Instantiates ttb_front, ttb_queue and ttb_back; depends on ttb_pkg.
//
// Usage:
//   Vertices enter on the vertex channel (vertex_valid, vertex_stall,
//   vertex), one request per vertex, three per triangle. Positions and
//   texture coordinates are signed Q16.16.
//   Each third vertex yields one request on the result channel
//   (result_valid, result_stall, result): tangent and bitangent, saturated
//   Q16.16, with degenerate and saturated flags. The first two vertices
//   of a triangle yield nothing.
//   The back end takes a new triangle only once the last is finished; its
//   bit-serial divider forms each of the six quotients one bit a cycle.
//   A two-entry queue holds finished vertex deltas, so the front takes
//   vertices while the back end works or waits on a stalled result.
//   When the receiver stalls, the result holds; once the queue fills the
//   third vertex of a triangle is stalled.
//   Reset clears the vertex count and empties the queue and output.
`timescale 1ns / 1ps
`default_nettype none

module triangle_tangent_bitangent
    import ttb_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    vertex_valid,
    output logic         vertex_stall,
    input  wire vertex_t vertex,
    output logic         result_valid,
    input  wire logic    result_stall,
    output result_t      result
);

    queue_ctl_t q_ctl;
    job_t       push_data;
    job_t       pop_data;
    logic       q_full;
    logic       pop_valid;
    logic       pop;

    ttb_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .vertex_valid (vertex_valid),
        .vertex_stall (vertex_stall),
        .vertex       (vertex),
        .q_full       (q_full),
        .q_ctl        (q_ctl),
        .q_data       (push_data)
    );

    ttb_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_ctl     (q_ctl),
        .push_data (push_data),
        .full      (q_full),
        .pop_valid (pop_valid),
        .pop       (pop),
        .pop_data  (pop_data)
    );

    ttb_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (pop_valid),
        .job          (pop_data),
        .job_pop      (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

`default_nettype wire

// File: hdl/ttb_front.sv
// Front end: accepts vertices, holds the first two of a triangle and forms
// the edge deltas on the third. Depends on ttb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ttb_front
    import ttb_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       vertex_valid,
    output logic            vertex_stall,
    input  wire vertex_t    vertex,
    input  wire logic       q_full,
    output queue_ctl_t      q_ctl,
    output job_t            q_data
);

    phase_t  phase_reg, phase_next;
    vertex_t first_reg, first_next;
    vertex_t second_reg, second_next;
    logic    accept;

    assign vertex_stall = (phase_reg == PH_THIRD) && q_full;
    assign accept       = vertex_valid && !vertex_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_FIRST;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_reg  <= first_next;
        second_reg <= second_next;
    end

    always_comb
    begin
        phase_next  = phase_reg;
        first_next  = first_reg;
        second_next = second_reg;
        q_ctl.push  = 1'b0;
        q_ctl.full  = q_full;
        if (accept)
        begin
            case (phase_reg)
                PH_SECOND:
                begin
                    second_next = vertex;
                    phase_next  = PH_THIRD;
                end
                PH_THIRD:
                begin
                    q_ctl.push = 1'b1;
                    phase_next = PH_FIRST;
                end
                default:
                begin
                    first_next = vertex;
                    phase_next = PH_SECOND;
                end
            endcase
        end
    end

    // Deltas carry one extra bit so the differences are exact.
    always_comb
    begin
        q_data.dp1[0] = DW1'(second_reg.pos_x) - DW1'(first_reg.pos_x);
        q_data.dp1[1] = DW1'(second_reg.pos_y) - DW1'(first_reg.pos_y);
        q_data.dp1[2] = DW1'(second_reg.pos_z) - DW1'(first_reg.pos_z);
        q_data.dp2[0] = DW1'(vertex.pos_x) - DW1'(first_reg.pos_x);
        q_data.dp2[1] = DW1'(vertex.pos_y) - DW1'(first_reg.pos_y);
        q_data.dp2[2] = DW1'(vertex.pos_z) - DW1'(first_reg.pos_z);
        q_data.du1    = DW1'(second_reg.tex_u) - DW1'(first_reg.tex_u);
        q_data.dv1    = DW1'(second_reg.tex_v) - DW1'(first_reg.tex_v);
        q_data.du2    = DW1'(vertex.tex_u) - DW1'(first_reg.tex_u);
        q_data.dv2    = DW1'(vertex.tex_v) - DW1'(first_reg.tex_v);
    end

endmodule

`default_nettype wire

// File: hdl/ttb_queue.sv
// Two-entry queue of triangle jobs between the front and back ends.
// Depends on ttb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ttb_queue
    import ttb_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire queue_ctl_t q_ctl,
    input  wire job_t       push_data,
    output logic            full,
    output logic            pop_valid,
    input  wire logic       pop,
    output job_t            pop_data
);

    job_t       mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign full      = (count_reg == 2'd2);
    assign pop_valid = (count_reg != 2'd0);
    assign pop_data  = mem_reg[rd_ptr_reg];
    assign do_push   = q_ctl.push && !q_ctl.full;
    assign do_pop    = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// File: hdl/ttb_back.sv
// Back end: one shared multiplier forms the determinant and the six
// numerators, a bit-serial divider forms each quotient, then it rounds,
// saturates and registers the result. Depends on ttb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ttb_back
    import ttb_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   job_valid,
    input  wire job_t   job,
    output logic        job_pop,
    output logic        result_valid,
    input  wire logic   result_stall,
    output result_t     result
);

    localparam logic [NSW-1:0] HALF = NSW'(1) << (DATA_WIDTH - 1);

    back_state_t            state_reg, state_next;
    logic                   out_valid_reg, out_valid_next;
    result_t                out_reg, out_next;
    job_t                   job_reg, job_next;
    logic [2:0]             sel_reg, sel_next;
    logic signed [PW-1:0]   prod_reg, prod_next;
    logic signed [NW-1:0]   acc_reg, acc_next;
    logic                   dneg_reg, dneg_next;
    logic [NW-1:0]          dmag_reg, dmag_next;
    logic                   nneg_reg, nneg_next;
    logic [NSW-1:0]         num_reg, num_next;
    logic [NW-1:0]          rr_reg, rr_next;
    logic [NSW-1:0]         q_reg, q_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic [DATA_WIDTH-1:0]  res_reg [6];
    logic [DATA_WIDTH-1:0]  res_val;
    logic                   res_we;
    logic                   sat_reg, sat_next;
    logic                   degen_reg, degen_next;

    logic signed [DW1-1:0]  mul_a, mul_b;
    logic [1:0]             comp;
    logic [NW-1:0]          acc_mag;
    logic [NW:0]            trial;
    logic                   trial_ge;
    logic [NW:0]            trial_sub;
    logic                   round_up;
    logic [NSW-1:0]         q_neg;

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // Operand selection for the shared multiplier.
    always_comb
    begin
        comp = (sel_reg >= SEL_BIT0) ? 2'(sel_reg - SEL_BIT0) : sel_reg[1:0];
        if (sel_reg == SEL_DET)
        begin
            mul_a = (state_reg == S_MUL1) ? job_reg.du1 : job_reg.dv1;
            mul_b = (state_reg == S_MUL1) ? job_reg.dv2 : job_reg.du2;
        end
        else if (sel_reg >= SEL_BIT0)
        begin
            mul_a = (state_reg == S_MUL1) ? job_reg.dp2[comp] : job_reg.dp1[comp];
            mul_b = (state_reg == S_MUL1) ? job_reg.du1 : job_reg.du2;
        end
        else
        begin
            mul_a = (state_reg == S_MUL1) ? job_reg.dp1[comp] : job_reg.dp2[comp];
            mul_b = (state_reg == S_MUL1) ? job_reg.dv2 : job_reg.dv1;
        end
        prod_next = mul_a * mul_b;
    end

    always_comb
    begin
        acc_mag   = acc_reg[NW-1] ? (NW'(0) - acc_reg) : acc_reg;
        trial     = {rr_reg, num_reg[NSW-1]};
        trial_ge  = trial >= {1'b0, dmag_reg};
        trial_sub = trial - {1'b0, dmag_reg};
        round_up  = {rr_reg, 1'b0} >= {1'b0, dmag_reg};
        q_neg     = NSW'(0) - q_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        job_next       = job_reg;
        sel_next       = sel_reg;
        acc_next       = acc_reg;
        dneg_next      = dneg_reg;
        dmag_next      = dmag_reg;
        nneg_next      = nneg_reg;
        num_next       = num_reg;
        rr_next        = rr_reg;
        q_next         = q_reg;
        cnt_next       = cnt_reg;
        sat_next       = sat_reg;
        degen_next     = degen_reg;
        res_val        = '0;
        res_we         = 1'b0;
        job_pop        = 1'b0;

        if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (job_valid)
                begin
                    job_pop    = 1'b1;
                    job_next   = job;
                    sel_next   = SEL_DET;
                    sat_next   = 1'b0;
                    degen_next = 1'b0;
                    state_next = S_MUL1;
                end
            end
            S_MUL1:
            begin
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                acc_next   = {prod_reg[PW-1], prod_reg};
                state_next = S_SUB;
            end
            S_SUB:
            begin
                acc_next   = acc_reg - {prod_reg[PW-1], prod_reg};
                state_next = S_ABS;
            end
            S_ABS:
            begin
                if (sel_reg == SEL_DET)
                begin
                    if (acc_reg == '0)
                    begin
                        degen_next = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        dneg_next  = acc_reg[NW-1];
                        dmag_next  = acc_mag;
                        sel_next   = '0;
                        state_next = S_MUL1;
                    end
                end
                else
                begin
                    nneg_next  = acc_reg[NW-1];
                    num_next   = {acc_mag, {FRAC_BITS{1'b0}}};
                    rr_next    = '0;
                    q_next     = '0;
                    cnt_next   = CW'(NSW - 1);
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                rr_next  = trial_ge ? trial_sub[NW-1:0] : trial[NW-1:0];
                q_next   = {q_reg[NSW-2:0], trial_ge};
                num_next = {num_reg[NSW-2:0], 1'b0};
                if (cnt_reg == '0)
                begin
                    state_next = S_ROUND;
                end
                else
                begin
                    cnt_next = cnt_reg - CW'(1);
                end
            end
            S_ROUND:
            begin
                q_next     = q_reg + {{(NSW-1){1'b0}}, round_up};
                state_next = S_SAT;
            end
            S_SAT:
            begin
                res_we = 1'b1;
                if (nneg_reg != dneg_reg)
                begin
                    if (q_reg > HALF)
                    begin
                        sat_next = 1'b1;
                        res_val  = HALF[DATA_WIDTH-1:0];
                    end
                    else
                    begin
                        res_val = q_neg[DATA_WIDTH-1:0];
                    end
                end
                else
                begin
                    if (q_reg > HALF - NSW'(1))
                    begin
                        sat_next = 1'b1;
                        res_val  = DATA_WIDTH'(HALF - NSW'(1));
                    end
                    else
                    begin
                        res_val = q_reg[DATA_WIDTH-1:0];
                    end
                end
                if (sel_reg == SEL_LAST)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    sel_next   = sel_reg + 3'd1;
                    state_next = S_MUL1;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    out_valid_next = 1'b1;
                    if (degen_reg)
                    begin
                        out_next            = '0;
                        out_next.degenerate = 1'b1;
                    end
                    else
                    begin
                        out_next.tangent_x   = res_reg[0];
                        out_next.tangent_y   = res_reg[1];
                        out_next.tangent_z   = res_reg[2];
                        out_next.bitangent_x = res_reg[3];
                        out_next.bitangent_y = res_reg[4];
                        out_next.bitangent_z = res_reg[5];
                        out_next.degenerate  = 1'b0;
                        out_next.saturated   = sat_reg;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg   <= out_next;
        job_reg   <= job_next;
        sel_reg   <= sel_next;
        prod_reg  <= prod_next;
        acc_reg   <= acc_next;
        dneg_reg  <= dneg_next;
        dmag_reg  <= dmag_next;
        nneg_reg  <= nneg_next;
        num_reg   <= num_next;
        rr_reg    <= rr_next;
        q_reg     <= q_next;
        cnt_reg   <= cnt_next;
        sat_reg   <= sat_next;
        degen_reg <= degen_next;
        if (res_we)
        begin
            res_reg[comp + (sel_reg >= SEL_BIT0 ? 3'd3 : 3'd0)] <= res_val;
        end
    end

    // A degenerate triangle reports zero vectors and never a clip.
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.degenerate |->
            !out_reg.saturated && out_reg.tangent_x == '0 && out_reg.bitangent_z == '0)
        else $error("degenerate result carries nonzero data");

    // The divider only runs against a nonzero divisor.
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> dmag_reg != '0)
        else $error("division started with zero divisor");

    // Rounding follows the last divide step.
    a_round_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ROUND |-> $past(state_reg) == S_DIV && $past(cnt_reg) == '0)
        else $error("rounding entered early");

endmodule

`default_nettype wire

// File: tb/sv/tb_triangle_tangent_bitangent.sv
// Self-checking testbench for triangle_tangent_bitangent: drives vertex streams,
// predicts each triangle's tangent and bitangent, and compares every result.
// Depends on ttb_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module tb_triangle_tangent_bitangent;
    import ttb_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 600;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    vertex_valid = 1'b0;
    logic    vertex_stall;
    vertex_t vertex = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;

    triangle_tangent_bitangent uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .vertex_valid (vertex_valid),
        .vertex_stall (vertex_stall),
        .vertex       (vertex),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always #1 clk = ~clk;

    // Predictor state: how many vertices of the current triangle are held.
    logic [1:0] held_count = 2'd0;
    vertex_t    corner_a;
    vertex_t    corner_b;
    result_t    pending_results[$];

    int vertices_sent   = 0;
    int results_checked = 0;
    int degenerate_seen = 0;
    int saturated_seen  = 0;
    int error_count     = 0;
    int idle_cycles     = 0;
    bit stall_quiet     = 1'b0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        $display("MISMATCH result %0d %s: got %h expected %h",
                 results_checked, what, got, want);
    endtask

    function automatic logic signed [127:0] coord(input vertex_t v, input int idx);
        logic signed [127:0] w;
        case (idx)
            0: w = v.pos_x;
            1: w = v.pos_y;
            2: w = v.pos_z;
            3: w = v.tex_u;
            default: w = v.tex_v;
        endcase
        return w;
    endfunction

    // Rounded quotient num * 2^FRAC_BITS / det, ties away from zero, clipped.
    function automatic logic [DATA_WIDTH-1:0] scaled_quotient(
        input logic signed [127:0] num, input logic signed [127:0] det,
        inout logic clipped);
        logic [127:0] n;
        logic [127:0] d;
        logic [127:0] q;
        logic [127:0] r;
        logic         neg;
        logic [127:0] half;
        neg  = num[127] ^ det[127];
        n    = num[127] ? -num : num;
        d    = det[127] ? -det : det;
        n    = n << FRAC_BITS;
        q    = n / d;
        r    = n % d;
        half = 128'd1 << (DATA_WIDTH - 1);
        if ((r << 1) >= d)
            q = q + 1;
        if (neg) begin
            if (q > half) begin
                clipped = 1'b1;
                q = half;
            end
            q = -q;
        end else if (q > half - 1) begin
            clipped = 1'b1;
            q = half - 1;
        end
        return q[DATA_WIDTH-1:0];
    endfunction

    function automatic result_t triangle_frame(input vertex_t a, input vertex_t b,
                                               input vertex_t c);
        result_t             res;
        logic signed [127:0] du1, dv1, du2, dv2, det, e1, e2;
        logic [DATA_WIDTH-1:0] t[3];
        logic [DATA_WIDTH-1:0] bt[3];
        logic                clipped;
        clipped = 1'b0;
        res = '0;
        du1 = coord(b, 3) - coord(a, 3);
        dv1 = coord(b, 4) - coord(a, 4);
        du2 = coord(c, 3) - coord(a, 3);
        dv2 = coord(c, 4) - coord(a, 4);
        det = du1 * dv2 - dv1 * du2;
        if (det == 0) begin
            res.degenerate = 1'b1;
            return res;
        end
        for (int i = 0; i < 3; i++) begin
            e1 = coord(b, i) - coord(a, i);
            e2 = coord(c, i) - coord(a, i);
            t[i]  = scaled_quotient(e1 * dv2 - e2 * dv1, det, clipped);
            bt[i] = scaled_quotient(e2 * du1 - e1 * du2, det, clipped);
        end
        res.tangent_x   = t[0];
        res.tangent_y   = t[1];
        res.tangent_z   = t[2];
        res.bitangent_x = bt[0];
        res.bitangent_y = bt[1];
        res.bitangent_z = bt[2];
        res.saturated   = clipped;
        return res;
    endfunction

    // Sampling at the rising edge: accepted vertices update the predictor,
    // accepted results are checked against the oldest expectation.
    always @(posedge clk) begin
        result_t want;
        if (rst_n) begin
            if (vertex_valid && !vertex_stall) begin
                vertices_sent++;
                case (held_count)
                    2'd0: begin
                        corner_a = vertex;
                        held_count = 2'd1;
                    end
                    2'd1: begin
                        corner_b = vertex;
                        held_count = 2'd2;
                    end
                    default: begin
                        pending_results.push_back(triangle_frame(corner_a, corner_b, vertex));
                        held_count = 2'd0;
                    end
                endcase
            end
            if (result_valid && !result_stall) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected request with nothing pending",
                                    32'd1, 32'd0);
                end else begin
                    want = pending_results.pop_front();
                    if (result.tangent_x !== want.tangent_x)
                        report_mismatch("tangent_x", result.tangent_x, want.tangent_x);
                    if (result.tangent_y !== want.tangent_y)
                        report_mismatch("tangent_y", result.tangent_y, want.tangent_y);
                    if (result.tangent_z !== want.tangent_z)
                        report_mismatch("tangent_z", result.tangent_z, want.tangent_z);
                    if (result.bitangent_x !== want.bitangent_x)
                        report_mismatch("bitangent_x", result.bitangent_x, want.bitangent_x);
                    if (result.bitangent_y !== want.bitangent_y)
                        report_mismatch("bitangent_y", result.bitangent_y, want.bitangent_y);
                    if (result.bitangent_z !== want.bitangent_z)
                        report_mismatch("bitangent_z", result.bitangent_z, want.bitangent_z);
                    if (result.degenerate !== want.degenerate)
                        report_mismatch("degenerate", result.degenerate, want.degenerate);
                    if (result.saturated !== want.saturated)
                        report_mismatch("saturated", result.saturated, want.saturated);
                    degenerate_seen += want.degenerate;
                    saturated_seen  += want.saturated;
                    results_checked++;
                end
            end
            if ((vertex_valid && !vertex_stall) || (result_valid && !result_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog expired with %0d results pending",
                         pending_results.size());
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    function automatic int gap_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Receiver stalls in bursts; quiet stretches leave it always ready.
    always @(negedge clk) begin
        int left;
        if (left > 0) begin
            left--;
        end else if (stall_quiet) begin
            result_stall = 1'b0;
        end else begin
            result_stall = !result_stall && ($urandom_range(0, 2) == 0);
            left = gap_length();
        end
    end

    task automatic send_vertex(input vertex_t v, input bit allow_gap);
        int seen;
        int gap;
        vertex = v;
        vertex_valid = 1'b1;
        seen = vertices_sent;
        do
            @(negedge clk);
        while (vertices_sent == seen);
        gap = allow_gap ? gap_length() : 0;
        if (gap > 0) begin
            vertex_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic send_triangle(input vertex_t a, input vertex_t b, input vertex_t c,
                                 input bit allow_gap);
        send_vertex(a, allow_gap);
        send_vertex(b, allow_gap);
        send_vertex(c, allow_gap);
    endtask

    function automatic vertex_t make_vertex(input int signed px, input int signed py,
                                            input int signed pz, input int signed u,
                                            input int signed v);
        vertex_t r;
        r.pos_x = px;
        r.pos_y = py;
        r.pos_z = pz;
        r.tex_u = u;
        r.tex_v = v;
        return r;
    endfunction

    function automatic logic [31:0] pick_value(input int mode);
        case (mode)
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            2: return $signed($urandom_range(0, 8 << 16)) - (4 << 16);
            default: return $signed($urandom_range(0, 1023)) - 512;
        endcase
    endfunction

    function automatic vertex_t random_vertex(input int mode);
        vertex_t r;
        r.pos_x = pick_value(mode);
        r.pos_y = pick_value(mode);
        r.pos_z = pick_value(mode);
        r.tex_u = pick_value(mode);
        r.tex_v = pick_value(mode);
        return r;
    endfunction

    task automatic wait_results_drained();
        vertex_valid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic test_directed();
        vertex_t lo, hi, z;
        lo = make_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                         32'h8000_0000, 32'h8000_0000);
        hi = make_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                         32'h7FFF_FFFF, 32'h7FFF_FFFF);
        z = '0;
        // Unit right triangle in position and UV.
        send_triangle(z, make_vertex(1 << 16, 0, 0, 1 << 16, 0),
                      make_vertex(0, 1 << 16, 0, 0, 1 << 16), 1'b0);
        // Zero determinant: all three UVs equal.
        send_triangle(make_vertex(5, 6, 7, 100, 100), make_vertex(9, -3, 2, 100, 100),
                      make_vertex(-8, 4, 1, 100, 100), 1'b1);
        // Collinear UVs, also a zero determinant.
        send_triangle(make_vertex(1, 2, 3, 0, 0), make_vertex(4, 5, 6, 1, 1),
                      make_vertex(7, 8, 9, 2, 2), 1'b1);
        // Tiny UV area against huge edges saturates high and low.
        send_triangle(lo, make_vertex(32'h7FFF_FFFF, 32'h8000_0000, 0, 1, 0),
                      make_vertex(0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 1), 1'b1);
        // Extremes of every field.
        send_triangle(lo, hi, lo, 1'b1);
        send_triangle(hi, lo, make_vertex(0, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF), 1'b0);
        // Det 2 with odd tangent numerators; the fraction shift makes each quotient exact.
        send_triangle(z, make_vertex(1, 1, 1, 2, 0), make_vertex(-1, 3, 0, 0, 1), 1'b1);
        send_triangle(make_vertex(-1, -1, -1, -1, -1), hi, hi, 1'b1);
    endtask

    task automatic test_random(input int vertex_budget);
        int mode;
        int stop_at;
        stop_at = vertices_sent + vertex_budget;
        while (vertices_sent < stop_at) begin
            stall_quiet = ($urandom_range(0, 9) == 0);
            mode = $urandom_range(0, 9);
            if (mode < 5)
                mode = 3;
            else if (mode < 7)
                mode = 2;
            else if (mode < 9)
                mode = 0;
            else
                mode = 1;
            if ($urandom_range(0, 7) == 0) begin
                // Degenerate by repeated texture coordinates.
                vertex_t a, b, c;
                a = random_vertex(mode);
                b = random_vertex(mode);
                c = random_vertex(mode);
                b.tex_u = a.tex_u;
                b.tex_v = a.tex_v;
                c.tex_u = a.tex_u;
                c.tex_v = a.tex_v;
                send_triangle(a, b, c, !stall_quiet);
            end else begin
                send_triangle(random_vertex(mode), random_vertex(mode),
                              random_vertex(mode), !stall_quiet);
            end
            if ($urandom_range(0, 40) == 0)
                wait_results_drained();
        end
        stall_quiet = 1'b0;
    endtask

    task automatic test_drained_pause();
        send_triangle(random_vertex(3), random_vertex(3), random_vertex(3), 1'b1);
        send_vertex(random_vertex(2), 1'b1);
        wait_results_drained();
        send_vertex(random_vertex(2), 1'b0);
        send_vertex(random_vertex(2), 1'b0);
    endtask

    initial begin
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_drained_pause();
        test_random(1250);
        vertex_valid = 1'b0;
        wait_results_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("Covered %0d vertices and %0d triangle results", vertices_sent,
                 results_checked);
        $display("Of those, %0d degenerate and %0d saturated", degenerate_seen,
                 saturated_seen);
        if (error_count == 0 && pending_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
